// ----- hdl/tsd_pkg.sv -----
// ----------------------------------------------------------------------------
// tsd_pkg
// shared widths, reset values and register map of the sensor trigger
// ----------------------------------------------------------------------------
package tsd_pkg;

   localparam int NUM_CH    = 3;
   localparam int CNT_W     = 8;
   localparam int PULSE_W   = 10;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   typedef logic [NUM_CH-1:0]  chan_vec_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [PULSE_W-1:0] pulse_type;

   localparam count_type CNT_MAX       = '1;
   localparam pulse_type ELAPSED_MAX   = '1;
   localparam count_type DEBOUNCE_RST  = 8'd15;
   localparam pulse_type PULSE_RST     = 10'd50;

   // register index, taken from paddr bit 2
   typedef enum logic {
      REG_DEBOUNCE = 1'b0,
      REG_PULSE    = 1'b1
   } reg_index_type;

endpackage

// ----- hdl/tsd_channels.sv -----
// ----------------------------------------------------------------------------
// tsd channels
// valid/ready channels carrying one sensor sample word and one result word
// ----------------------------------------------------------------------------
interface tsd_req_if;
   logic valid;
   logic ready;
   logic sensor_top;
   logic sensor_mid;
   logic sensor_bot;

   modport source (output valid, output sensor_top, output sensor_mid,
                   output sensor_bot, input ready);
   modport sink   (input valid, input sensor_top, input sensor_mid,
                   input sensor_bot, output ready);
endinterface

interface tsd_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 drive_out;
   logic                 fired;
   tsd_pkg::chan_vec_type filtered_levels;
   tsd_pkg::chan_vec_type seen_flags;

   modport source (output valid, output drive_out, output fired,
                   output filtered_levels, output seen_flags, input ready);
   modport sink   (input valid, input drive_out, input fired,
                   input filtered_levels, input seen_flags, output ready);
endinterface

// ----- hdl/three_sensor_debounce_pulse_trigger.sv -----
// ----------------------------------------------------------------------------
// three_sensor_debounce_pulse_trigger
// debounced three-sensor arrival tracker with a one-shot pulse output
// ----------------------------------------------------------------------------
// Each request word is one tick (nominally 1 ms) of three raw active-low
// sensor levels. Every channel is debounced by a saturating count of stable
// ticks; a new level is taken once the count exceeds debounce_ms. A debounced
// fall marks the channel as seen, a debounced rise fires the pulse if that
// channel was seen and no higher one (top over middle over bottom) is. A fire
// clears all seen flags and restarts the pulse, which lasts pulse_ms ticks.
// One result word comes back per request word. The block takes one word per
// clock while rsp is not stalled: a word is latched in the input register,
// evaluated against the channel state by combinational logic and written to
// the result register, which also serves as the output skid. The csr port
// holds debounce_ms at 0x0 and pulse_ms at 0x4; write only when idle.
// ----------------------------------------------------------------------------
module three_sensor_debounce_pulse_trigger (
   input  logic                         clock,
   input  logic                         reset,
   tsd_req_if.sink                      req_chan,
   tsd_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsd_pkg::ADDR_W-1:0]   paddr,
   input  logic [tsd_pkg::DATA_W-1:0]   pwdata,
   output logic [tsd_pkg::DATA_W-1:0]   prdata,
   output logic                         pready
);

   // configuration registers
   tsd_pkg::count_type debounce_ms_ff;
   tsd_pkg::pulse_type pulse_ms_ff;

   // input register
   logic                  in_valid_ff;
   tsd_pkg::chan_vec_type in_raw_ff;

   // channel state
   tsd_pkg::chan_vec_type previous_raw_ff, previous_raw_in;
   tsd_pkg::chan_vec_type stable_level_ff, stable_level_in;
   tsd_pkg::count_type    stable_count_ff [tsd_pkg::NUM_CH];
   tsd_pkg::count_type    stable_count_in [tsd_pkg::NUM_CH];
   tsd_pkg::chan_vec_type arrival_flag_ff, arrival_flag_in;
   logic                  pulse_on_ff, pulse_on_in;
   tsd_pkg::pulse_type    pulse_elapsed_ff, pulse_elapsed_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  drive_out_ff;
   logic                  fired_ff;
   tsd_pkg::chan_vec_type filtered_ff;
   tsd_pkg::chan_vec_type seen_ff;

   logic                  out_free;
   logic                  advance;
   logic                  req_take;
   logic                  csr_write;
   tsd_pkg::reg_index_type csr_index;

   tsd_pkg::chan_vec_type changed;
   tsd_pkg::chan_vec_type flag_mid;
   logic                  fire;
   tsd_pkg::pulse_type    elapsed_inc;

   // handshakes: the result register frees up when empty or being taken
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign advance   = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_take  = req_chan.valid && req_chan.ready;

   assign csr_index = tsd_pkg::reg_index_type'(paddr[2]);
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         tsd_pkg::REG_DEBOUNCE: prdata = {{(tsd_pkg::DATA_W-tsd_pkg::CNT_W){1'b0}},
                                          debounce_ms_ff};
         tsd_pkg::REG_PULSE:    prdata = {{(tsd_pkg::DATA_W-tsd_pkg::PULSE_W){1'b0}},
                                          pulse_ms_ff};
         default:               prdata = '0;
      endcase
   end

   // per-tick evaluation of the latched sample against the channel state
   always_comb begin
      // pulse timing runs before the channels are looked at
      elapsed_inc      = (pulse_elapsed_ff == tsd_pkg::ELAPSED_MAX) ?
                         pulse_elapsed_ff : pulse_elapsed_ff + 1'b1;
      pulse_on_in      = pulse_on_ff;
      pulse_elapsed_in = pulse_elapsed_ff;
      if (pulse_on_ff) begin
         pulse_elapsed_in = elapsed_inc;
         if (elapsed_inc >= pulse_ms_ff) pulse_on_in = 1'b0;
      end

      // debounce each channel
      previous_raw_in = in_raw_ff;
      stable_level_in = stable_level_ff;
      for (int ch = 0; ch < tsd_pkg::NUM_CH; ch++) begin
         if (in_raw_ff[ch] != previous_raw_ff[ch])
            stable_count_in[ch] = '0;
         else if (stable_count_ff[ch] == tsd_pkg::CNT_MAX)
            stable_count_in[ch] = stable_count_ff[ch];
         else
            stable_count_in[ch] = stable_count_ff[ch] + 1'b1;
         changed[ch] = (stable_count_in[ch] > debounce_ms_ff) &&
                       (in_raw_ff[ch] != stable_level_ff[ch]);
         if (changed[ch]) stable_level_in[ch] = in_raw_ff[ch];
      end

      // a debounced fall marks arrival
      flag_mid = arrival_flag_ff | (changed & ~in_raw_ff);

      // only the highest debounced rise is examined
      if (changed[0] && in_raw_ff[0])
         fire = flag_mid[0];
      else if (changed[1] && in_raw_ff[1])
         fire = flag_mid[1] && !flag_mid[0];
      else if (changed[2] && in_raw_ff[2])
         fire = flag_mid[2] && !flag_mid[0] && !flag_mid[1];
      else
         fire = 1'b0;

      arrival_flag_in = flag_mid;
      if (fire) begin
         pulse_on_in      = 1'b1;
         pulse_elapsed_in = '0;
         arrival_flag_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff   <= tsd_pkg::DEBOUNCE_RST;
         pulse_ms_ff      <= tsd_pkg::PULSE_RST;
         in_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         previous_raw_ff  <= '1;
         stable_level_ff  <= '1;
         arrival_flag_ff  <= '0;
         pulse_on_ff      <= 1'b0;
         pulse_elapsed_ff <= '0;
         for (int ch = 0; ch < tsd_pkg::NUM_CH; ch++) stable_count_ff[ch] <= '0;
      end else begin
         // csr writes
         if (csr_write) begin
            case (csr_index)
               tsd_pkg::REG_DEBOUNCE: debounce_ms_ff <= pwdata[tsd_pkg::CNT_W-1:0];
               tsd_pkg::REG_PULSE:    pulse_ms_ff    <= pwdata[tsd_pkg::PULSE_W-1:0];
               default: ;
            endcase
         end

         // input register
         if (req_take) begin
            in_valid_ff <= 1'b1;
            in_raw_ff   <= {req_chan.sensor_bot, req_chan.sensor_mid,
                            req_chan.sensor_top};
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end

         // state and result register move together
         if (advance) begin
            previous_raw_ff  <= previous_raw_in;
            stable_level_ff  <= stable_level_in;
            arrival_flag_ff  <= arrival_flag_in;
            pulse_on_ff      <= pulse_on_in;
            pulse_elapsed_ff <= pulse_elapsed_in;
            for (int ch = 0; ch < tsd_pkg::NUM_CH; ch++)
               stable_count_ff[ch] <= stable_count_in[ch];
            rsp_valid_ff <= 1'b1;
            drive_out_ff <= pulse_on_in;
            fired_ff     <= fire;
            filtered_ff  <= stable_level_in;
            seen_ff      <= arrival_flag_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.drive_out       = drive_out_ff;
   assign rsp_chan.fired           = fired_ff;
   assign rsp_chan.filtered_levels = filtered_ff;
   assign rsp_chan.seen_flags      = seen_ff;

endmodule
